[src/csargb_pkg.sv]
package csargb_pkg;

   localparam int CompW       = 17;
   localparam int FracW       = 12;
   localparam int MulW        = 29;
   localparam int TermW       = 27;
   localparam int BriW        = 25;
   localparam int ProdW       = BriW + TermW;
   localparam int ProdShift   = 28;
   localparam int QuotW       = ProdW - ProdShift;
   localparam int RecipW      = 23;
   localparam int RecipShift  = 36;
   localparam int RecQW       = 22;
   localparam int RecProdW    = RecQW + RecipW;

   localparam logic [CompW-1:0]  SectorUnits = 17'd3840;
   localparam logic [CompW-1:0]  HueLimit    = 17'd26880;
   localparam logic [TermW-1:0]  FullTerm    = 27'd98304000;
   localparam logic [QuotW-1:0]  SatLimit    = 24'd2400000;
   localparam logic [RecipW-1:0] RecipMul    = 23'd7330078;
   localparam logic [16:0]       QOne        = 17'd65536;
   localparam logic [7:0]        AlphaByte   = 8'hFF;

   typedef enum logic [1:0] {
      CMD_RGB  = 2'd0,
      CMD_HSB  = 2'd1,
      CMD_CMYK = 2'd2,
      CMD_GRAY = 2'd3
   } cmd_type;

   typedef struct packed {
      logic        is_hsb;
      logic        ok;
      logic [2:0]  sector;
      logic [23:0] flat;
   } info_type;

   function automatic logic [BriW-1:0] mul255(input logic [CompW-1:0] x);
      logic [BriW-1:0] w;
      w = {8'b0, x};
      return (w << 8) - w;
   endfunction

   function automatic logic [7:0] sat8(input logic [9:0] v);
      return (v > 10'd255) ? 8'hFF : v[7:0];
   endfunction

   // floor(255 * x / 2^16)
   function automatic logic [7:0] trunc_scale(input logic [CompW-1:0] x);
      logic [BriW-1:0] m;
      m = mul255(x);
      return sat8({1'b0, m[24:16]});
   endfunction

   // floor((255 * x + 2^15) / 2^16)
   function automatic logic [7:0] round_scale(input logic [CompW-1:0] x);
      logic [BriW:0] m;
      m = {1'b0, mul255(x)} + 26'd32768;
      return sat8(m[25:16]);
   endfunction

endpackage

[src/csargb_front.sv]
module csargb_front (
   input  logic                           clock,
   input  logic                           advance,
   input  logic [1:0]                     req_command,
   input  logic [csargb_pkg::CompW-1:0]   req_comp_a,
   input  logic [csargb_pkg::CompW-1:0]   req_comp_b,
   input  logic [csargb_pkg::CompW-1:0]   req_comp_c,
   input  logic [csargb_pkg::CompW-1:0]   req_comp_d,
   output csargb_pkg::info_type           info,
   output logic [csargb_pkg::FracW-1:0]   frac,
   output logic [csargb_pkg::CompW-1:0]   sat,
   output logic [csargb_pkg::CompW-1:0]   bri
);
   import csargb_pkg::*;

   cmd_type          cmd;
   logic [2:0]       sec_raw;
   logic [CompW-1:0] sec_base;
   logic [16:0]      cy_term, mg_term, yl_term;
   logic [7:0]       gray;
   info_type         info_in, info_ff;
   logic [FracW-1:0] frac_in, frac_ff;
   logic [CompW-1:0] sat_ff, bri_ff;

   function automatic logic [16:0] cmyk_term(input logic [CompW-1:0] col,
                                            input logic [CompW-1:0] blk);
      logic [CompW:0] sub;
      sub = {1'b0, col} + {1'b0, blk};
      return (sub >= {1'b0, QOne}) ? 17'd0 : 17'({1'b0, QOne} - sub);
   endfunction

   always_comb begin
      cmd = cmd_type'(req_command);
      sec_raw = 3'd0;
      for (int k = 1; k <= 6; k++) begin
         if (req_comp_a >= 17'(k * 3840)) begin
            sec_raw = 3'(k);
         end
      end
      sec_base = 17'({14'b0, sec_raw} * SectorUnits);
      frac_in  = FracW'(req_comp_a - sec_base);

      cy_term = cmyk_term(req_comp_a, req_comp_d);
      mg_term = cmyk_term(req_comp_b, req_comp_d);
      yl_term = cmyk_term(req_comp_c, req_comp_d);
      gray    = round_scale(req_comp_a);

      info_in.is_hsb = (cmd == CMD_HSB);
      info_in.ok     = !((cmd == CMD_HSB) && (req_comp_a >= HueLimit));
      // hue from 360 up to 420 degrees reuses sector 0
      info_in.sector = (sec_raw == 3'd6) ? 3'd0 : sec_raw;
      case (cmd)
         CMD_RGB: begin
            info_in.flat = {trunc_scale(req_comp_a), trunc_scale(req_comp_b),
                            trunc_scale(req_comp_c)};
         end
         CMD_CMYK: begin
            info_in.flat = {round_scale(cy_term), round_scale(mg_term),
                            round_scale(yl_term)};
         end
         CMD_GRAY: begin
            info_in.flat = {gray, gray, gray};
         end
         default: begin
            info_in.flat = 24'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         info_ff <= info_in;
         frac_ff <= frac_in;
         sat_ff  <= req_comp_b;
         bri_ff  <= req_comp_c;
      end
   end

   assign info = info_ff;
   assign frac = frac_ff;
   assign sat  = sat_ff;
   assign bri  = bri_ff;

endmodule

[src/csargb_terms.sv]
module csargb_terms (
   input  logic                              clock,
   input  logic                              advance,
   input  csargb_pkg::info_type              info,
   input  logic [csargb_pkg::FracW-1:0]      frac,
   input  logic [csargb_pkg::CompW-1:0]      sat,
   input  logic [csargb_pkg::CompW-1:0]      bri,
   output csargb_pkg::info_type              info_out,
   output logic [csargb_pkg::BriW-1:0]       bri255,
   output logic [2:0][csargb_pkg::TermW-1:0] terms
);
   import csargb_pkg::*;

   info_type           info2_ff, info3_ff;
   logic [MulW-1:0]    sfr_in, sinv_in, sfull_in;
   logic [MulW-1:0]    sfr_ff, sinv_ff, sfull_ff;
   logic [BriW-1:0]    bri2_ff, bri3_ff;
   logic [FracW-1:0]   rest;
   logic [TermW-1:0]   tp, tq, tt;
   logic [2:0][TermW-1:0] terms_in, terms_ff;

   // full * (1 - m / full), negative terms clamp to zero
   function automatic logic [TermW-1:0] clamp_term(input logic [MulW-1:0] m);
      return (m >= {2'b0, FullTerm}) ? '0 : TermW'({2'b0, FullTerm} - m);
   endfunction

   always_comb begin
      rest     = FracW'(SectorUnits) - frac;
      sfr_in   = MulW'({12'b0, sat} * {17'b0, frac});
      sinv_in  = MulW'({12'b0, sat} * {17'b0, rest});
      sfull_in = MulW'({12'b0, sat} * {12'b0, SectorUnits});
   end

   always_comb begin
      tp = clamp_term(sfull_ff);
      tq = clamp_term(sfr_ff);
      tt = clamp_term(sinv_ff);
      // terms are red, green, blue in lanes 2, 1, 0
      case (info2_ff.sector)
         3'd0:    terms_in = {FullTerm, tt, tp};
         3'd1:    terms_in = {tq, FullTerm, tp};
         3'd2:    terms_in = {tp, FullTerm, tt};
         3'd3:    terms_in = {tp, tq, FullTerm};
         3'd4:    terms_in = {tt, tp, FullTerm};
         default: terms_in = {FullTerm, tp, tq};
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         info2_ff <= info;
         sfr_ff   <= sfr_in;
         sinv_ff  <= sinv_in;
         sfull_ff <= sfull_in;
         bri2_ff  <= mul255(bri);
         info3_ff <= info2_ff;
         bri3_ff  <= bri2_ff;
         terms_ff <= terms_in;
      end
   end

   assign info_out = info3_ff;
   assign bri255   = bri3_ff;
   assign terms    = terms_ff;

endmodule

[src/csargb_scale.sv]
module csargb_scale (
   input  logic                           clock,
   input  logic                           advance,
   input  logic [csargb_pkg::BriW-1:0]    bri255,
   input  logic [csargb_pkg::TermW-1:0]   term,
   output logic [7:0]                     chan
);
   import csargb_pkg::*;

   logic [ProdW-1:0]    prod_in, prod_ff;
   logic [QuotW-1:0]    quo;
   logic                sat_in, sat_ff;
   logic [RecProdW-1:0] rec_in, rec_ff;
   logic [7:0]          chan_in, chan_ff;

   // divisor is 2^28 * 9375; the 9375 part goes through a reciprocal
   always_comb begin
      prod_in = {{TermW{1'b0}}, bri255} * {{BriW{1'b0}}, term};
      quo     = prod_ff[ProdW-1:ProdShift];
      sat_in  = (quo >= SatLimit);
      rec_in  = {{RecipW{1'b0}}, quo[RecQW-1:0]} * {{RecQW{1'b0}}, RecipMul};
      chan_in = sat_ff ? 8'hFF : rec_ff[RecipShift+7:RecipShift];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
         sat_ff  <= sat_in;
         rec_ff  <= rec_in;
         chan_ff <= chan_in;
      end
   end

   assign chan = chan_ff;

endmodule

[src/color_spec_to_argb.sv]
// a request passes the front, terms, scale and output registers from accept to response valid
// throughput: one request per cycle when the response side keeps up
// a stalled response freezes the whole pipeline, nothing is dropped or repeated
// the hsb path sets the depth: two multiplier stages and a reciprocal divide
// synchronous active-high reset clears the valid bits only
module color_spec_to_argb (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_command,
   input  logic [csargb_pkg::CompW-1:0] req_comp_a,
   input  logic [csargb_pkg::CompW-1:0] req_comp_b,
   input  logic [csargb_pkg::CompW-1:0] req_comp_c,
   input  logic [csargb_pkg::CompW-1:0] req_comp_d,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [31:0]                  rsp_argb,
   output logic                         rsp_valid_res
);
   import csargb_pkg::*;

   localparam int Depth = 7;

   logic                  advance;
   logic [Depth-1:0]      vld_in, vld_ff;
   info_type              info1, info3;
   logic [FracW-1:0]      frac1;
   logic [CompW-1:0]      sat1, bri1;
   logic [BriW-1:0]       bri255;
   logic [2:0][TermW-1:0] terms;
   logic [2:0][7:0]       chans;
   info_type [2:0]        info_dly_ff;
   logic [31:0]           argb_in, argb_ff;
   logic                  res_in, res_ff;

   assign advance = !vld_ff[Depth-1] || rsp_ready;
   assign req_ready = advance;

   csargb_front u_front (
      .clock       (clock),
      .advance     (advance),
      .req_command (req_command),
      .req_comp_a  (req_comp_a),
      .req_comp_b  (req_comp_b),
      .req_comp_c  (req_comp_c),
      .req_comp_d  (req_comp_d),
      .info        (info1),
      .frac        (frac1),
      .sat         (sat1),
      .bri         (bri1)
   );

   csargb_terms u_terms (
      .clock    (clock),
      .advance  (advance),
      .info     (info1),
      .frac     (frac1),
      .sat      (sat1),
      .bri      (bri1),
      .info_out (info3),
      .bri255   (bri255),
      .terms    (terms)
   );

   for (genvar i = 0; i < 3; i++) begin : g_chan
      csargb_scale u_scale (
         .clock   (clock),
         .advance (advance),
         .bri255  (bri255),
         .term    (terms[i]),
         .chan    (chans[i])
      );
   end

   always_comb begin
      vld_in = {vld_ff[Depth-2:0], req_valid};
      res_in = info_dly_ff[2].ok;
      if (!info_dly_ff[2].ok) begin
         argb_in = 32'd0;
      end else if (info_dly_ff[2].is_hsb) begin
         argb_in = {AlphaByte, chans[2], chans[1], chans[0]};
      end else begin
         argb_in = {AlphaByte, info_dly_ff[2].flat};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         info_dly_ff <= {info_dly_ff[1:0], info3};
         argb_ff     <= argb_in;
         res_ff      <= res_in;
      end
   end

   assign rsp_valid     = vld_ff[Depth-1];
   assign rsp_argb      = argb_ff;
   assign rsp_valid_res = res_ff;

   a_bad_hue_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |-> rsp_argb == 32'd0)
      else $error("bad hue response carries a nonzero color");

   a_alpha_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_valid_res |-> rsp_argb[31:24] == AlphaByte)
      else $error("good response lacks full alpha");

   a_enter_pipe: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> vld_ff[0])
      else $error("accepted request missing from first stage");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(vld_ff))
      else $error("pipeline moved during a stall");

endmodule

[tb/color_spec_to_argb_tb.sv]
module color_spec_to_argb_tb;
   import csargb_pkg::*;

   localparam int       ItemCount  = 1750;
   localparam int       CycleLimit = 200000;
   localparam int       DrainWait  = 20;
   localparam longint   HueSector  = 3840;
   localparam longint   PctFull    = 25600;
   localparam longint   QFull      = 65536;
   localparam longint   HsbFull    = PctFull * HueSector;
   localparam longint   HsbDen     = PctFull * PctFull * HueSector;
   localparam logic [CompW-1:0] CompMax = '1;

   typedef struct {
      logic [31:0] argb;
      logic        ok;
   } color_word_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_RANDOM,
      STALL_SHORT,
      STALL_LONG
   } stall_kind_type;

   class color_scoreboard_type;
      color_word_type expected_q[$];
      int             errors;

      function new();
         errors = 0;
      endfunction

      function automatic logic [7:0] clip8(longint v);
         return (v > 255) ? 8'hFF : v[7:0];
      endfunction

      function automatic logic [7:0] hsb_byte(longint num);
         if (num < 0) return 8'h00;
         return clip8(num / HsbDen);
      endfunction

      function automatic logic [7:0] cmyk_byte(longint col, longint blk);
         longint sub;
         longint term;
         sub  = col + blk;
         term = (sub >= QFull) ? 0 : QFull - sub;
         return clip8((255 * term + 32768) >> 16);
      endfunction

      function automatic color_word_type hsb_word(logic [CompW-1:0] hue, sat, bri);
         color_word_type w;
         longint    sec, fr, s, base, nv, np, nq, nt;
         logic [7:0] rb, gb, bb;
         sec = longint'(hue) / HueSector;
         fr  = longint'(hue) % HueSector;
         s   = longint'(sat);
         w.argb = '0;
         w.ok   = 1'b0;
         if (sec > 6) return w;
         // 360 to 420 degrees folds back onto the red sector
         if (sec == 6) sec = 0;
         base = 255 * longint'(bri);
         nv = base * HsbFull;
         np = base * ((PctFull - s) * HueSector);
         nq = base * (HsbFull - s * fr);
         nt = base * (HsbFull - s * (HueSector - fr));
         case (sec)
            0: begin rb = hsb_byte(nv); gb = hsb_byte(nt); bb = hsb_byte(np); end
            1: begin rb = hsb_byte(nq); gb = hsb_byte(nv); bb = hsb_byte(np); end
            2: begin rb = hsb_byte(np); gb = hsb_byte(nv); bb = hsb_byte(nt); end
            3: begin rb = hsb_byte(np); gb = hsb_byte(nq); bb = hsb_byte(nv); end
            4: begin rb = hsb_byte(nt); gb = hsb_byte(np); bb = hsb_byte(nv); end
            default: begin rb = hsb_byte(nv); gb = hsb_byte(np); bb = hsb_byte(nq); end
         endcase
         w.argb = {8'hFF, rb, gb, bb};
         w.ok   = 1'b1;
         return w;
      endfunction

      function automatic color_word_type convert(cmd_type cmd, logic [CompW-1:0] a, b, c, d);
         color_word_type w;
         logic [7:0]     lvl;
         w.ok = 1'b1;
         case (cmd)
            CMD_RGB: w.argb = {8'hFF, clip8((255 * longint'(a)) >> 16),
                               clip8((255 * longint'(b)) >> 16),
                               clip8((255 * longint'(c)) >> 16)};
            CMD_HSB: w = hsb_word(a, b, c);
            CMD_CMYK: w.argb = {8'hFF, cmyk_byte(longint'(a), longint'(d)),
                                cmyk_byte(longint'(b), longint'(d)),
                                cmyk_byte(longint'(c), longint'(d))};
            default: begin
               lvl = clip8((255 * longint'(a) + 32768) >> 16);
               w.argb = {8'hFF, lvl, lvl, lvl};
            end
         endcase
         return w;
      endfunction

      function void note(cmd_type cmd, logic [CompW-1:0] a, b, c, d);
         expected_q.push_back(convert(cmd, a, b, c, d));
      endfunction

      task report(string msg);
         $display("error: %s", msg);
         errors++;
      endtask

      task check(logic [31:0] argb, logic ok);
         color_word_type w;
         if (expected_q.size() == 0) begin
            report($sformatf("response argb=%h valid_res=%b with no request pending",
                             argb, ok));
            return;
         end
         w = expected_q.pop_front();
         if (argb !== w.argb)
            report($sformatf("argb got %h expected %h", argb, w.argb));
         if (ok !== w.ok)
            report($sformatf("valid_res got %b expected %b", ok, w.ok));
      endtask

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   logic [1:0]       req_command;
   logic [CompW-1:0] req_comp_a;
   logic [CompW-1:0] req_comp_b;
   logic [CompW-1:0] req_comp_c;
   logic [CompW-1:0] req_comp_d;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [31:0]      rsp_argb;
   logic             rsp_valid_res;

   color_scoreboard_type sb;
   int                   cycles = 0;
   int                   stall_cnt = 0;
   stall_kind_type       stall_mode = STALL_NONE;

   color_spec_to_argb uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_command   (req_command),
      .req_comp_a    (req_comp_a),
      .req_comp_b    (req_comp_b),
      .req_comp_c    (req_comp_c),
      .req_comp_d    (req_comp_d),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_argb      (rsp_argb),
      .rsp_valid_res (rsp_valid_res)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CycleLimit) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // receiver stall pattern, re-picked periodically at random from the four stall kinds
   always @(negedge clock) begin
      stall_cnt = stall_cnt + 1;
      if (stall_cnt % 97 == 0) stall_mode = stall_kind_type'($urandom_range(0, 3));
      case (stall_mode)
         STALL_NONE:   rsp_ready = 1'b1;
         STALL_RANDOM: rsp_ready = ($urandom_range(0, 3) != 0);
         STALL_SHORT:  rsp_ready = (stall_cnt % 7) >= 3;
         default:      rsp_ready = (stall_cnt % 23) >= 15;
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check(rsp_argb, rsp_valid_res);
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task send_item(cmd_type cmd, logic [CompW-1:0] a, b, c, d);
      req_valid   = 1'b1;
      req_command = cmd;
      req_comp_a  = a;
      req_comp_b  = b;
      req_comp_c  = c;
      req_comp_d  = d;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note(cmd, a, b, c, d);
      @(negedge clock);
   endtask

   // mostly in 0..1.0, with the edges and the full 17-bit range mixed in
   function automatic logic [CompW-1:0] rand_level(logic [CompW-1:0] one);
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return one;
         2, 3:    return CompW'($urandom_range(0, CompMax));
         default: return CompW'($urandom_range(0, one));
      endcase
   endfunction

   task random_item();
      cmd_type          cmd;
      logic [CompW-1:0] a, b, c, d;
      cmd = cmd_type'($urandom_range(0, 3));
      d   = CompW'($urandom_range(0, CompMax));
      case (cmd)
         CMD_HSB: begin
            case ($urandom_range(0, 7))
               0:       a = CompW'($urandom_range(0, CompMax));
               1:       a = CompW'($urandom_range(0, 7) * HueSector
                                   + $urandom_range(0, 2) - 1);
               default: a = CompW'($urandom_range(0, 26879));
            endcase
            b = rand_level(CompW'(PctFull));
            c = rand_level(CompW'(PctFull));
         end
         CMD_GRAY: begin
            a = rand_level(CompW'(QFull));
            b = CompW'($urandom_range(0, CompMax));
            c = CompW'($urandom_range(0, CompMax));
         end
         default: begin
            a = rand_level(CompW'(QFull));
            b = rand_level(CompW'(QFull));
            c = rand_level(CompW'(QFull));
            if (cmd == CMD_CMYK) d = rand_level(CompW'(QFull));
         end
      endcase
      send_item(cmd, a, b, c, d);
   endtask

   initial begin
      int sent;
      int burst;
      int gap;
      sb          = new();
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_command = CMD_RGB;
      req_comp_a  = '0;
      req_comp_b  = '0;
      req_comp_c  = '0;
      req_comp_d  = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_item(CMD_RGB, 0, 0, 0, 0);
      send_item(CMD_RGB, 65536, 65536, 65536, CompMax);
      send_item(CMD_RGB, CompMax, 65535, 1, 0);
      send_item(CMD_RGB, 256, 257, 32768, 12345);
      send_item(CMD_GRAY, 0, CompMax, CompMax, CompMax);
      send_item(CMD_GRAY, 129, 0, 0, 0);
      send_item(CMD_GRAY, 32768, 1, 2, 3);
      send_item(CMD_GRAY, 65536, 0, 0, 0);
      send_item(CMD_GRAY, CompMax, 0, 0, 0);
      // white, black, terms driven negative by large ink, and a plain mixed color
      send_item(CMD_CMYK, 0, 0, 0, 0);
      send_item(CMD_CMYK, 0, 0, 0, 65536);
      send_item(CMD_CMYK, 65536, 40000, CompMax, 30000);
      send_item(CMD_CMYK, 1000, 20000, 30000, 0);
      send_item(CMD_HSB, 0, 25600, 25600, CompMax);
      send_item(CMD_HSB, 3840, 25600, 25600, 0);
      send_item(CMD_HSB, 9600, 12800, 25600, 0);
      send_item(CMD_HSB, 11520 + 100, 25600, 20000, 0);
      send_item(CMD_HSB, 15360 + 3839, 20000, 25600, 0);
      send_item(CMD_HSB, 19200 + 1920, 25600, 25600, 0);
      send_item(CMD_HSB, 23040 + 960, 25600, 25600, 0);
      send_item(CMD_HSB, 26879, 25600, 25600, 0);
      send_item(CMD_HSB, 26880, 25600, 25600, 0);
      send_item(CMD_HSB, CompMax, CompMax, CompMax, CompMax);
      send_item(CMD_HSB, 1000, CompMax, 25600, 0);
      send_item(CMD_HSB, 5000, 0, CompMax, 0);

      sent = 0;
      while (sent < ItemCount) begin
         burst = $urandom_range(1, 24);
         for (int i = 0; i < burst; i++) random_item();
         sent += burst;
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_valid = 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DrainWait) @(posedge clock);
      if (sb.errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

[filelist.f]
src/csargb_pkg.sv
src/csargb_front.sv
src/csargb_terms.sv
src/csargb_scale.sv
src/color_spec_to_argb.sv
tb/color_spec_to_argb_tb.sv
